// ===== src/bcp_pkg.sv =====
package bcp_pkg;

    // fixed point and loop constants
    localparam int FRAC_BITS   = 8;
    localparam int INTEG_BOUND = 20000;

    // datapath widths
    localparam int ACC_W   = 64;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 18;
    localparam int NUM_W   = 22;
    localparam int DIV_W   = 21;
    localparam int INTEG_W = 16;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 5;

    // filter divisor for 0.3 / 0.7 blend
    localparam logic [4:0] FILT_DIV = 5'd10;

    // configuration register indexes
    localparam logic [3:0] REG_UP_P   = 4'd0;
    localparam logic [3:0] REG_UP_D   = 4'd1;
    localparam logic [3:0] REG_SP_P   = 4'd2;
    localparam logic [3:0] REG_SP_I   = 4'd3;
    localparam logic [3:0] REG_TN_P   = 4'd4;
    localparam logic [3:0] REG_TN_D   = 4'd5;
    localparam logic [3:0] REG_OFFSET = 4'd6;
    localparam logic [3:0] REG_LIMIT  = 4'd7;

    // reset values (offset is 5.5 degrees in Q8.8)
    localparam logic signed [16:0] OFFSET_RESET = 17'sd1408;
    localparam logic [14:0]        LIMIT_RESET  = 15'd7000;

    typedef logic signed [ACC_W-1:0] acc_t;

    // divide by 2^sh, rounding toward zero
    function automatic acc_t trunc_shift(input acc_t v, input int sh);
        acc_t bias;
        bias = v[ACC_W-1] ? ((acc_t'(1) <<< sh) - acc_t'(1)) : acc_t'(0);
        return (v + bias) >>> sh;
    endfunction

endpackage

// ===== src/balance_cascade_pid_step.sv =====
// Cascaded PID step for a two-wheel balancing robot.
// Input channel s_*: one word per control tick carrying wheel counts, tilt
// angle, gyro rates and the speed and turn targets; s_tuser carries the
// integral clear request. Output channel m_*: one word per tick with the
// left and right motor drives, each saturated to +/- drive_limit.
// Configuration: cfg_wr_en, cfg_addr, cfg_wdata write gains, the balance
// offset and the drive limit; write them only while the block is idle.
// The filter uses a restoring divide by ten, one quotient bit per cycle,
// and the six gain products go through one shift-add multiplier that takes
// one gain bit per cycle, plus load and post steps. A new word is taken
// once the previous result sits in the output register, even while that
// result waits.
// Reset (aresetn low, synchronous) clears the filter and integral state,
// sets gains to zero, offset to 5.5 and limit to 7000, and drops m_tvalid.
// When the receiver stalls, the result holds in m_tdata and the block
// finishes at most one more word, then waits with s_tready low.
module balance_cascade_pid_step
    import bcp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_count[15:0], right_raw_count[31:16], roll_angle[48:32],
    // pitch_rate[64:49], yaw_rate[80:65], speed_target[96:81],
    // turn_target[112:97], zero fill above
    input  logic [119:0] s_tdata,
    // clear_integral[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_drive[15:0], right_drive[31:16]
    output logic [31:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_addr,
    input  logic [16:0]  cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ERR   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_INTEG = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_POST  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // configuration registers
    logic signed [GAIN_W-1:0] up_p_reg, up_d_reg, sp_p_reg, sp_i_reg;
    logic signed [GAIN_W-1:0] tn_p_reg, tn_d_reg;
    logic signed [16:0]       offset_reg;
    logic [14:0]              limit_reg;

    // loop state
    logic signed [ERR_W-1:0]   filt_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // latched input word
    logic signed [15:0] left_reg, right_reg, pitch_reg, yaw_reg, spd_reg, turn_t_reg;
    logic signed [16:0] roll_reg;
    logic               clear_reg;

    // sequencer
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]       sel_reg;

    // serial divider
    logic [DIV_W-1:0] div_reg;
    logic [3:0]       rem_reg;
    logic             neg_reg;

    // serial multiplier and intermediates
    acc_t              acc_reg, mcand_reg, diff_reg, upright_reg;
    logic [GAIN_W-1:0] mplier_reg;

    logic [31:0] m_tdata_reg;
    logic        m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // filter numerator 3*err + 7*previous
    logic signed [ERR_W-1:0] err;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_abs;
    assign err = ERR_W'(left_reg) - ERR_W'(right_reg) - ERR_W'(spd_reg);
    assign num = (NUM_W'(err) <<< 1) + NUM_W'(err)
               + (NUM_W'(filt_reg) <<< 3) - NUM_W'(filt_reg);
    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // one restoring divide step
    logic [4:0] div_trial;
    logic       div_ge;
    assign div_trial = {rem_reg, div_reg[DIV_W-1]};
    assign div_ge    = (div_trial >= FILT_DIV);

    // integrator with clamp
    logic signed [ERR_W-1:0] filt_val;
    logic signed [SUM_W-1:0] integ_sum;
    logic signed [INTEG_W-1:0] integ_val;
    assign filt_val  = neg_reg ? -ERR_W'(div_reg) : ERR_W'(div_reg);
    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(filt_val);
    always_comb begin
        if (integ_sum > SUM_W'(INTEG_BOUND)) begin
            integ_val = INTEG_W'(INTEG_BOUND);
        end else if (integ_sum < -SUM_W'(INTEG_BOUND)) begin
            integ_val = -INTEG_W'(INTEG_BOUND);
        end else begin
            integ_val = INTEG_W'(integ_sum);
        end
    end

    // multiplier operand select
    logic signed [GAIN_W-1:0] gain_sel;
    acc_t                     opnd_sel;
    always_comb begin
        case (sel_reg)
            3'd0: begin gain_sel = sp_p_reg; opnd_sel = acc_t'(filt_reg); end
            3'd1: begin gain_sel = sp_i_reg; opnd_sel = acc_t'(integ_reg); end
            3'd2: begin gain_sel = up_p_reg; opnd_sel = diff_reg; end
            3'd3: begin gain_sel = up_d_reg; opnd_sel = acc_t'(pitch_reg) <<< FRAC_BITS; end
            3'd4: begin gain_sel = tn_p_reg; opnd_sel = acc_t'(turn_t_reg); end
            default: begin gain_sel = tn_d_reg; opnd_sel = acc_t'(yaw_reg); end
        endcase
    end

    // one shift-add step, sign bit of the gain subtracts
    acc_t mac_term, mac_next;
    assign mac_term = mplier_reg[0] ? mcand_reg : acc_t'(0);
    assign mac_next = (cnt_reg == CNT_W'(GAIN_W - 1)) ? acc_reg - mac_term
                                                      : acc_reg + mac_term;

    // post processing of finished sums
    acc_t speed_val, setpt_val, turn_val, left_val, right_val;
    acc_t lim_pos, lim_neg;
    logic signed [15:0] left_sat, right_sat;
    assign speed_val = trunc_shift(acc_reg, FRAC_BITS);
    assign setpt_val = (speed_val <<< FRAC_BITS) + acc_t'(offset_reg);
    assign turn_val  = trunc_shift(acc_reg, FRAC_BITS);
    assign left_val  = upright_reg - turn_val;
    assign right_val = upright_reg + turn_val;
    assign lim_pos   = acc_t'(limit_reg);
    assign lim_neg   = -acc_t'(limit_reg);
    always_comb begin
        if (left_val > lim_pos) begin
            left_sat = 16'(lim_pos);
        end else if (left_val < lim_neg) begin
            left_sat = 16'(lim_neg);
        end else begin
            left_sat = 16'(left_val);
        end
        if (right_val > lim_pos) begin
            right_sat = 16'(lim_pos);
        end else if (right_val < lim_neg) begin
            right_sat = 16'(lim_neg);
        end else begin
            right_sat = 16'(right_val);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_ERR;
            ST_ERR:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == CNT_W'(DIV_W - 1)) state_next = ST_INTEG;
            ST_INTEG: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == CNT_W'(GAIN_W - 1)) begin
                state_next = sel_reg[0] ? ST_POST : ST_LOAD;
            end
            ST_POST:  state_next = (sel_reg == 3'd5) ? ST_OUT : ST_LOAD;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_p_reg   <= '0;
            up_d_reg   <= '0;
            sp_p_reg   <= '0;
            sp_i_reg   <= '0;
            tn_p_reg   <= '0;
            tn_d_reg   <= '0;
            offset_reg <= OFFSET_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_UP_P:   up_p_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_UP_D:   up_d_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_SP_P:   sp_p_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_SP_I:   sp_i_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_TN_P:   tn_p_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_TN_D:   tn_d_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_OFFSET: offset_reg <= cfg_wdata;
                REG_LIMIT:  limit_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            sel_reg      <= '0;
            filt_reg     <= '0;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result valid: set on a new result, cleared when taken
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ERR: cnt_reg <= '0;
                ST_DIV: cnt_reg <= cnt_reg + 1'b1;
                ST_INTEG: begin
                    filt_reg  <= filt_val;
                    integ_reg <= clear_reg ? '0 : integ_val;
                    sel_reg   <= '0;
                end
                ST_LOAD: cnt_reg <= '0;
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(GAIN_W - 1) && !sel_reg[0]) begin
                        sel_reg <= sel_reg + 1'b1;
                    end
                end
                ST_POST: sel_reg <= sel_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                left_reg   <= s_tdata[15:0];
                right_reg  <= s_tdata[31:16];
                roll_reg   <= s_tdata[48:32];
                pitch_reg  <= s_tdata[64:49];
                yaw_reg    <= s_tdata[80:65];
                spd_reg    <= s_tdata[96:81];
                turn_t_reg <= s_tdata[112:97];
                clear_reg  <= s_tuser;
            end
            ST_ERR: begin
                div_reg <= num_abs[DIV_W-1:0];
                rem_reg <= '0;
                neg_reg <= num[NUM_W-1];
            end
            ST_DIV: begin
                rem_reg <= div_ge ? 4'(div_trial - FILT_DIV) : div_trial[3:0];
                div_reg <= {div_reg[DIV_W-2:0], div_ge};
            end
            ST_LOAD: begin
                mcand_reg  <= opnd_sel;
                mplier_reg <= gain_sel;
                if (!sel_reg[0]) acc_reg <= '0;
            end
            ST_MUL: begin
                acc_reg    <= mac_next;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
            end
            ST_POST: begin
                if (sel_reg == 3'd1) diff_reg <= acc_t'(roll_reg) - setpt_val;
                if (sel_reg == 3'd3) upright_reg <= trunc_shift(acc_reg, 2 * FRAC_BITS);
            end
            ST_OUT: if (!m_tvalid_reg || m_tready) begin
                m_tdata_reg <= {right_sat, left_sat};
            end
            default: ;
        endcase
    end

endmodule

// ===== src/bcp_checker.sv =====
module bcp_checker
    import bcp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_wr_en,
    input logic [3:0]  cfg_addr,
    input logic [16:0] cfg_wdata
);

    // track the drive limit from the config port
    logic [14:0] lim_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= LIMIT_RESET;
        end else if (cfg_wr_en && cfg_addr == REG_LIMIT) begin
            lim_reg <= cfg_wdata[14:0];
        end
    end

    logic signed [16:0] left_w, right_w, lim_w;
    assign left_w  = 17'(signed'(m_tdata[15:0]));
    assign right_w = 17'(signed'(m_tdata[31:16]));
    assign lim_w   = 17'(lim_reg);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a result never appears the cycle after an accept
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // drives stay within the limit
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> left_w <= lim_w && left_w >= -lim_w
                         && right_w <= lim_w && right_w >= -lim_w)
        else $error("drive beyond limit");

endmodule

bind balance_cascade_pid_step bcp_checker u_bcp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
);

// ===== bench/balance_cascade_pid_step_tb.sv =====
module balance_cascade_pid_step_tb;
    import bcp_pkg::*;

    typedef struct packed {
        logic signed [15:0] left_count;
        logic signed [15:0] right_raw_count;
        logic signed [16:0] roll_angle;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] speed_target;
        logic signed [15:0] turn_target;
        logic               clear_integral;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
    } drive_t;

    localparam int LATENCY = 200;
    localparam longint CYCLE_LIMIT = 2000000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_wr_en;
    logic [3:0]   cfg_addr;
    logic [16:0]  cfg_wdata;

    balance_cascade_pid_step DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // controller model state and registers
    longint gain_reg [8];
    longint filt_state;
    longint integ_state;

    tick_t  pending_ticks [$];
    drive_t expected_drives [$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_cycles;
    bit     hold_request;
    bit     failed;
    longint cycle_count;

    function automatic longint div_trunc(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / b;
        return (a < 0) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lim);
        return v < -lim ? -lim : (v > lim ? lim : v);
    endfunction

    // one control tick of the cascaded loops
    function automatic drive_t control_tick(tick_t t);
        longint err, filt, integ, speed, setpt, upright, turn, lim;
        drive_t d;
        err = longint'(t.left_count) - longint'(t.right_raw_count)
              - longint'(t.speed_target);
        filt = div_trunc(3 * err + 7 * filt_state, 10);
        filt_state = filt;
        integ = clip(integ_state + filt, INTEG_BOUND);
        if (t.clear_integral) integ = 0;
        integ_state = integ;
        speed = div_trunc(gain_reg[2] * filt + gain_reg[3] * integ, 256);
        setpt = speed * 256 + gain_reg[6];
        upright = div_trunc(gain_reg[0] * (longint'(t.roll_angle) - setpt)
                            + gain_reg[1] * longint'(t.pitch_rate) * 256, 65536);
        turn = div_trunc(gain_reg[4] * longint'(t.turn_target)
                         + gain_reg[5] * longint'(t.yaw_rate), 256);
        lim = gain_reg[7];
        d.left_drive = 16'(clip(upright - turn, lim));
        d.right_drive = 16'(clip(upright + turn, lim));
        return d;
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    logic taken_last;
    always @(posedge aclk) taken_last <= s_tvalid && s_tready;

    // driver
    always @(negedge aclk) begin
        tick_t t;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (taken_last && s_tvalid) void'(pending_ticks.pop_front());
            if ((!s_tvalid || taken_last) && pending_ticks.size() > 0
                && !hold_request && $urandom_range(99) >= send_idle_pct) begin
                t = pending_ticks[0];
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, t.turn_target, t.speed_target, t.yaw_rate,
                            t.pitch_rate, t.roll_angle, t.right_raw_count,
                            t.left_count};
                s_tuser <= t.clear_integral;
            end else if (taken_last || !s_tvalid) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge aclk) begin
        tick_t t;
        if (aresetn && s_tvalid && s_tready) begin
            t.left_count = s_tdata[15:0];
            t.right_raw_count = s_tdata[31:16];
            t.roll_angle = s_tdata[48:32];
            t.pitch_rate = s_tdata[64:49];
            t.yaw_rate = s_tdata[80:65];
            t.speed_target = s_tdata[96:81];
            t.turn_target = s_tdata[112:97];
            t.clear_integral = s_tuser;
            expected_drives.push_back(control_tick(t));
        end
    end

    // receiver ready, with a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        drive_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_drives.size() == 0) begin
                $display("%0t unexpected word: actual %h", $time, m_tdata);
                failed <= 1'b1;
            end else begin
                want = expected_drives.pop_front();
                if (m_tdata[15:0] !== want.left_drive) begin
                    $display("%0t left_drive mismatch: expected %0d actual %0d",
                             $time, want.left_drive, $signed(m_tdata[15:0]));
                    failed <= 1'b1;
                end
                if (m_tdata[31:16] !== want.right_drive) begin
                    $display("%0t right_drive mismatch: expected %0d actual %0d",
                             $time, want.right_drive, $signed(m_tdata[31:16]));
                    failed <= 1'b1;
                end
            end
        end
    end

    task automatic write_reg(input logic [3:0] idx, input longint value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= 17'(value);
        if (idx == REG_LIMIT) gain_reg[7] = value & 32'h7fff;
        else if (idx == REG_OFFSET) gain_reg[6] = longint'($signed(17'(value)));
        else if (idx <= REG_TN_D) gain_reg[idx] = longint'($signed(16'(value)));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || s_tvalid || expected_drives.size() > 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic tick_t random_tick(int mag);
        tick_t t;
        t.left_count = $urandom_range(1) ? 16'($urandom) : 16'($signed($urandom_range(2*mag)) - mag);
        t.right_raw_count = $urandom_range(1) ? 16'($urandom) : 16'($signed($urandom_range(2*mag)) - mag);
        t.roll_angle = 17'($signed($urandom_range(92160)) - 46080);
        t.pitch_rate = 16'($urandom);
        t.yaw_rate = 16'($urandom);
        t.speed_target = 16'($urandom);
        t.turn_target = 16'($urandom);
        t.clear_integral = ($urandom_range(15) == 0);
        return t;
    endfunction

    function automatic longint random_gain();
        case ($urandom_range(5))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return longint'($signed($urandom_range(4096))) - 2048;
        endcase
    endfunction

    initial begin
        tick_t t;
        longint sizes [3];
        cycle_count = 0;
        failed = 1'b0;
        hold_request = 1'b0;
        hold_off_cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 72;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_UP_P;
        cfg_wdata = '0;
        for (int i = 0; i < 6; i++) gain_reg[i] = 0;
        gain_reg[6] = 1408;
        gain_reg[7] = 7000;
        filt_state = 0;
        integ_state = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset settings, then full-scale gains and extremes
        t = '0;
        pending_ticks.push_back(t);
        wait_drained();
        write_reg(REG_UP_P, 32767);
        write_reg(REG_UP_D, -32768);
        write_reg(REG_SP_P, 32767);
        write_reg(REG_SP_I, -32768);
        write_reg(REG_TN_P, 32767);
        write_reg(REG_TN_D, -32768);
        write_reg(REG_OFFSET, -46080);
        write_reg(REG_LIMIT, 32767);
        for (int i = 0; i < 12; i++) begin
            t.left_count = (i % 2) ? 16'sh7fff : 16'sh8000;
            t.right_raw_count = (i % 3 == 0) ? 16'sh7fff : 16'sh8000;
            t.roll_angle = (i % 2) ? 17'sd46080 : -17'sd46080;
            t.pitch_rate = (i % 4 < 2) ? 16'sh7fff : 16'sh8000;
            t.yaw_rate = (i % 2) ? 16'sh8000 : 16'sh7fff;
            t.speed_target = (i % 3 == 1) ? 16'sh7fff : 16'sh8000;
            t.turn_target = (i % 2) ? 16'sh7fff : 16'sh8000;
            t.clear_integral = (i == 6);
            pending_ticks.push_back(t);
        end
        wait_drained();
        // zero limit forces drives to zero; unused index is ignored
        write_reg(REG_LIMIT, 0);
        write_reg(4'd12, 17'h1ffff);
        write_reg(REG_OFFSET, 46080);
        for (int i = 0; i < 4; i++) pending_ticks.push_back(random_tick(32768));
        wait_drained();
        write_reg(REG_LIMIT, 1);
        for (int i = 0; i < 4; i++) pending_ticks.push_back(random_tick(32768));
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 72;
                recv_idle_pct = 10;
            end
            if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int r = 0; r < 6; r++) write_reg(4'(r), random_gain());
            write_reg(REG_OFFSET, longint'($signed($urandom_range(92160))) - 46080);
            write_reg(REG_LIMIT, (ph == 5) ? 32767 : $urandom_range(32767));
            for (int i = 0; i < 250; i++) begin
                pending_ticks.push_back(random_tick((i % 50 < 40) ? 200 : 32768));
                if (ph == 1 && i == 100) begin
                    // long receiver stall while words keep coming
                    while (pending_ticks.size() > 0) @(posedge aclk);
                    @(negedge aclk);
                    hold_off_cycles = 1200;
                end
                if (ph == 3 && i == 120) begin
                    // sender pause until everything is back
                    while (pending_ticks.size() > 0 || s_tvalid
                           || expected_drives.size() > 0) @(posedge aclk);
                end
            end
            wait_drained();
        end

        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
